### rtl/core/rmd160_pkg.sv
package rmd160_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_EMIT
  } state_t;

  // command bundle from controller to datapath
  typedef struct packed {
    logic       buf_wr;      // write buf_byte at buf_addr
    logic [5:0] buf_addr;
    logic [7:0] buf_byte;
    logic       cnt_inc;     // advance byte count
    logic       comp_start;  // load working words from chaining words
    logic       comp_step;   // run one round
    logic       comp_fin;    // fold working words into chaining words
    logic       restart;     // back to initial value, count to zero
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;        // byte count mod 64
    logic [6:0] round;      // current round index
    logic [63:0] bits;      // bit length of message
  } sts_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [4:0] MAX_DIGEST = 5'd20;

  function automatic logic [3:0] word_l(input logic [6:0] j);
    logic [319:0] t;
    t = {4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,
         4'd15,
         4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,
         4'd8,
         4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,
         4'd12,
         4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,
         4'd2,
         4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,
         4'd13};
    return t[319 - 4*j -: 4];
  endfunction

  function automatic logic [3:0] word_r(input logic [6:0] j);
    logic [319:0] t;
    t = {4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,
         4'd12,
         4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,
         4'd2,
         4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,
         4'd13,
         4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,
         4'd14,
         4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,
         4'd11};
    return t[319 - 4*j -: 4];
  endfunction

  function automatic logic [3:0] rot_l(input logic [6:0] j);
    logic [319:0] t;
    t = {4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,
         4'd9,4'd8,
         4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,
         4'd12,
         4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,
         4'd5,
         4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,
         4'd12,
         4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,4'd5,
         4'd6};
    return t[319 - 4*j -: 4];
  endfunction

  function automatic logic [3:0] rot_r(input logic [6:0] j);
    logic [319:0] t;
    t = {4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,
         4'd12,4'd6,
         4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,
         4'd11,
         4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,
         4'd5,
         4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,
         4'd8,
         4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,4'd11,
         4'd11};
    return t[319 - 4*j -: 4];
  endfunction

  function automatic logic [31:0] add_l(input logic [2:0] g);
    case (g)
      3'd0: return 32'h00000000;
      3'd1: return 32'h5A827999;
      3'd2: return 32'h6ED9EBA1;
      3'd3: return 32'h8F1BBCDC;
      default: return 32'hA953FD4E;
    endcase
  endfunction

  function automatic logic [31:0] add_r(input logic [2:0] g);
    case (g)
      3'd0: return 32'h50A28BE6;
      3'd1: return 32'h5C4DD124;
      3'd2: return 32'h6D703EF3;
      3'd3: return 32'h7A6D76E9;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic [31:0] boolfn(input logic [2:0] g, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
    case (g)
      3'd0: return x ^ y ^ z;
      3'd1: return (x & y) | (~x & z);
      3'd2: return (x | ~y) ^ z;
      3'd3: return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

endpackage

### rtl/core/rmd160_dp.sv
module rmd160_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rmd160_pkg::cmd_t  cmd,
  input  logic [4:0]        rd_sel,
  output rmd160_pkg::sts_t  sts,
  output logic [7:0]        rd_byte
);

  // block buffer kept as sixteen little-endian message words
  logic [31:0] buf_r [16];
  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [60:0] cnt_r;
  logic [6:0]  rnd_r;
  logic [31:0] al_r, bl_r, cl_r, dl_r, el_r;
  logic [31:0] ar_r, br_r, cr_r, dr_r, er_r;
  logic [31:0] ml, mr, tl, tr;
  logic [2:0]  g;
  logic [3:0]  il, ir;

  assign g  = 3'(rnd_r[6:4]);
  assign il = rmd160_pkg::word_l(rnd_r);
  assign ir = rmd160_pkg::word_r(rnd_r);
  assign ml = buf_r[il];
  assign mr = buf_r[ir];
  assign tl = rmd160_pkg::rotl(al_r + rmd160_pkg::boolfn(g, bl_r, cl_r, dl_r) + ml
                + rmd160_pkg::add_l(g), rmd160_pkg::rot_l(rnd_r)) + el_r;
  assign tr = rmd160_pkg::rotl(ar_r + rmd160_pkg::boolfn(3'd4 - g, br_r, cr_r, dr_r) + mr
                + rmd160_pkg::add_r(g), rmd160_pkg::rot_r(rnd_r)) + er_r;

  assign h_nxt[0] = h_r[1] + cl_r + dr_r;
  assign h_nxt[1] = h_r[2] + dl_r + er_r;
  assign h_nxt[2] = h_r[3] + el_r + ar_r;
  assign h_nxt[3] = h_r[4] + al_r + br_r;
  assign h_nxt[4] = h_r[0] + bl_r + cr_r;

  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      buf_r[cmd.buf_addr[5:2]][{cmd.buf_addr[1:0], 3'd0} +: 8] <= cmd.buf_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      h_r[0] <= rmd160_pkg::IV0;
      h_r[1] <= rmd160_pkg::IV1;
      h_r[2] <= rmd160_pkg::IV2;
      h_r[3] <= rmd160_pkg::IV3;
      h_r[4] <= rmd160_pkg::IV4;
      cnt_r  <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 61'd1;
      end
      if (cmd.comp_fin) begin
        for (int k = 0; k < 5; k++) begin
          h_r[k] <= h_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (cmd.comp_start) begin
      rnd_r <= '0;
    end else if (cmd.comp_step) begin
      rnd_r <= rnd_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      al_r <= h_r[0]; bl_r <= h_r[1]; cl_r <= h_r[2]; dl_r <= h_r[3]; el_r <= h_r[4];
      ar_r <= h_r[0]; br_r <= h_r[1]; cr_r <= h_r[2]; dr_r <= h_r[3]; er_r <= h_r[4];
    end else if (cmd.comp_step) begin
      al_r <= el_r; el_r <= dl_r; dl_r <= rmd160_pkg::rotl(cl_r, 4'd10);
      cl_r <= bl_r; bl_r <= tl;
      ar_r <= er_r; er_r <= dr_r; dr_r <= rmd160_pkg::rotl(cr_r, 4'd10);
      cr_r <= br_r; br_r <= tr;
    end
  end

  assign sts.pos   = cnt_r[5:0];
  assign sts.round = rnd_r;
  assign sts.bits  = {cnt_r, 3'd0};
  assign rd_byte   = 8'(h_r[rd_sel[4:2]] >> {rd_sel[1:0], 3'd0});

endmodule

### rtl/core/rmd160_ctrl.sv
module rmd160_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_byte_present,
  input  logic              in_message_end,
  input  logic [4:0]        dlen,
  input  rmd160_pkg::sts_t  sts,
  output rmd160_pkg::cmd_t  cmd,
  output logic [4:0]        rd_sel,
  output logic              emit_valid,
  output logic              emit_last,
  input  logic              emit_stall
);

  rmd160_pkg::state_t state_r, state_nxt;
  logic       pend_end_r, pend_end_nxt;   // message end waits behind a compression
  logic       final_r, final_nxt;         // running compression is the last block
  logic [5:0] pad_r, pad_nxt;             // padding write pointer
  logic       pad_two_r, pad_two_nxt;     // padding needs a first block flush
  logic       mark_r, mark_nxt;           // next padding write is the 0x80 marker
  logic       pad_two_now;
  logic [4:0] idx_r, idx_nxt;
  logic [4:0] n_bytes;
  logic       acc;

  assign n_bytes     = (dlen > rmd160_pkg::MAX_DIGEST) ? rmd160_pkg::MAX_DIGEST : dlen;
  assign acc         = in_valid && !in_stall;
  assign rd_sel      = idx_r;
  assign pad_two_now = mark_r ? (pad_r >= 6'd56) : pad_two_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rmd160_pkg::ST_IDLE;
      pend_end_r <= 1'b0;
      final_r    <= 1'b0;
      pad_r      <= '0;
      pad_two_r  <= 1'b0;
      mark_r     <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_end_r <= pend_end_nxt;
      final_r    <= final_nxt;
      pad_r      <= pad_nxt;
      pad_two_r  <= pad_two_nxt;
      mark_r     <= mark_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pend_end_nxt = pend_end_r;
    final_nxt    = final_r;
    pad_nxt      = pad_r;
    pad_two_nxt  = pad_two_r;
    mark_nxt     = mark_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    in_stall     = 1'b1;
    emit_valid   = 1'b0;
    emit_last    = 1'b0;
    case (state_r)
      rmd160_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (acc) begin
          if (in_byte_present) begin
            cmd.buf_wr   = 1'b1;
            cmd.buf_addr = sts.pos;
            cmd.buf_byte = in_data_byte;
            cmd.cnt_inc  = 1'b1;
          end
          if (in_byte_present && sts.pos == 6'd63) begin
            cmd.comp_start = 1'b1;
            final_nxt      = 1'b0;
            pend_end_nxt   = in_message_end;
            mark_nxt       = in_message_end;
            pad_nxt        = '0;
            state_nxt      = rmd160_pkg::ST_COMP;
          end else if (in_message_end) begin
            // 0x80 goes at the position after any byte in this item
            mark_nxt  = 1'b1;
            pad_nxt   = in_byte_present ? sts.pos + 6'd1 : sts.pos;
            state_nxt = rmd160_pkg::ST_PAD;
          end
        end
      end
      rmd160_pkg::ST_COMP: begin
        if (sts.round == 7'd80) begin
          cmd.comp_fin = 1'b1;
          if (final_r) begin
            idx_nxt   = '0;
            state_nxt = (n_bytes == 5'd0) ? rmd160_pkg::ST_IDLE : rmd160_pkg::ST_EMIT;
            if (n_bytes == 5'd0) begin
              cmd.restart = 1'b1;
            end
          end else if (pend_end_r) begin
            // message end after a full block or a marker flush: pad a fresh block
            pend_end_nxt = 1'b0;
            pad_nxt      = '0;
            pad_two_nxt  = 1'b0;
            state_nxt    = rmd160_pkg::ST_PAD;
          end else begin
            state_nxt = rmd160_pkg::ST_IDLE;
          end
        end else begin
          cmd.comp_step = 1'b1;
        end
      end
      rmd160_pkg::ST_PAD: begin
        // one buffer byte per cycle: marker if due, zeros, then the length on the last pass
        cmd.buf_wr   = 1'b1;
        cmd.buf_addr = pad_r;
        if (mark_r) begin
          cmd.buf_byte = 8'h80;
        end else if (!pad_two_now && pad_r >= 6'd56) begin
          cmd.buf_byte = 8'(sts.bits >> {pad_r[2:0], 3'd0});
        end else begin
          cmd.buf_byte = 8'h00;
        end
        mark_nxt    = 1'b0;
        pad_two_nxt = pad_two_now;
        pad_nxt     = pad_r + 6'd1;
        if (pad_r == 6'd63) begin
          cmd.comp_start = 1'b1;
          final_nxt      = !pad_two_now;
          pend_end_nxt   = pad_two_now;
          pad_two_nxt    = 1'b0;
          state_nxt      = rmd160_pkg::ST_COMP;
        end
      end
      rmd160_pkg::ST_EMIT: begin
        emit_valid = 1'b1;
        emit_last  = (idx_r + 5'd1 == n_bytes);
        if (!emit_stall) begin
          idx_nxt = idx_r + 5'd1;
          if (emit_last) begin
            cmd.restart = 1'b1;
            state_nxt   = rmd160_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rmd160_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/ripemd160_stream_hash.sv
// ripemd-160 stream hash, one item per message byte
// a byte item is written to the block buffer; one that fills a block starts a compression
// message end: padding to the block end and one or two compressions, then min(digest_length, 20)
// result items, one a cycle while out_stall is low; no items when digest_length is zero
// input stalls from a block fill or message end until the round loop or digest output is done
// rst_n synchronous active low: initial chaining value, count zero, digest_length 20
module ripemd160_stream_hash (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_message_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_digest_byte,
  output logic [4:0] out_byte_position,
  output logic       out_last_of_digest
);

  rmd160_pkg::cmd_t cmd;
  rmd160_pkg::sts_t sts;
  logic [4:0] dlen_r;
  logic [4:0] rd_sel;
  logic [7:0] rd_byte;
  logic       emit_valid, emit_last;

  // digest length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlen_r <= rmd160_pkg::MAX_DIGEST;
    end else if (cfg_wr_en) begin
      dlen_r <= cfg_wr_data;
    end
  end

  rmd160_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_byte_present,
    .in_message_end, .dlen(dlen_r), .sts, .cmd, .rd_sel,
    .emit_valid, .emit_last, .emit_stall(out_stall)
  );

  rmd160_dp u_dp (
    .clk, .rst_n, .cmd, .rd_sel, .sts, .rd_byte
  );

  // digest bytes come straight from the chaining words, held while stalled
  assign out_valid          = emit_valid;
  assign out_digest_byte    = rd_byte;
  assign out_byte_position  = rd_sel;
  assign out_last_of_digest = emit_last;

`ifndef NO_ASSERTIONS
  // no input item taken while digest bytes are going out
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted during digest output");

  // positions climb by one within a digest
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_digest) |=>
      (out_valid && out_byte_position == $past(out_byte_position) + 5'd1))
    else $error("digest position skipped");

  // first byte of a digest is position zero
  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_byte_position == 5'd0)
    else $error("digest does not start at zero");
`endif

endmodule
